// ===== rtl/scle_pkg.sv =====
// ----------------------------------------------------------------------------
// scle_pkg: shared types and constants
// Scancode set 1 character ROM, result kinds, decode actions, control types.
// ----------------------------------------------------------------------------
package scle_pkg;

  localparam int LINE_DEPTH = 20;
  localparam int FILL_W     = $clog2(LINE_DEPTH);
  localparam int LEN_W      = 5;
  localparam int CNT_W      = 16;

  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_SAT  = {CNT_W{1'b1}};

  localparam logic [6:0] CODE_FIRST     = 7'h01;
  localparam logic [6:0] CODE_LAST      = 7'h58;
  localparam logic [6:0] CODE_BACKSPACE = 7'h0e;
  localparam logic [6:0] CODE_PREFIX1   = 7'(8'he0 & 8'h7f);
  localparam logic [6:0] CODE_PREFIX2   = 7'(8'he1 & 8'h7f);
  localparam logic [7:0] RELEASE_BIT    = 8'h80;
  localparam logic [7:0] NONE_CH        = 8'hff;
  localparam logic [7:0] NEWLINE_CH     = 8'h0a;

  // character for codes 0x01..0x58, entry 0 is code 0x01
  localparam logic [7:0] CHAR_ROM [0:87] = '{
    8'hff, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h2d, 8'h3d, 8'hff, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75,
    8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'hff, 8'h61, 8'h73, 8'h64, 8'h66,
    8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b, 8'h27, 8'h60, 8'hff, 8'h5c, 8'h7a,
    8'h78, 8'h63, 8'h76, 8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'hff, 8'h2a,
    8'hff, 8'h20, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'h37, 8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36,
    8'h2b, 8'h31, 8'h32, 8'h33, 8'h30, 8'h2e, 8'h61, 8'h62, 8'h5c, 8'hff, 8'hff
  };

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_FAULT  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ACT_HELD,
    ACT_SKIP,
    ACT_PFX1,
    ACT_PFX2,
    ACT_FAULT,
    ACT_NONE,
    ACT_BKSP,
    ACT_EMIT,
    ACT_DROP,
    ACT_APPEND
  } act_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_STAT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic stat_load;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic is_emit;
    logic emit_last;
    logic out_free;
  } stat_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       character;
    logic             last;
    logic [LEN_W-1:0] line_length;
    logic [CNT_W-1:0] overflow_count;
  } res_t;

endpackage

// ===== rtl/scle_out_stage.sv =====
// ----------------------------------------------------------------------------
// scle_out_stage: result output register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module scle_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  scle_pkg::res_t load_data,
  output logic          free,
  input  logic          out_tready,
  output logic          out_tvalid,
  output scle_pkg::res_t out_data
);
  import scle_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t data_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_data   = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

// ===== rtl/scle_dpath.sv =====
// ----------------------------------------------------------------------------
// scle_dpath: scancode decode and line datapath
// Decodes the held byte, keeps skip, fill, overflow and fault state, and owns
// the line store with its registered read port.
// ----------------------------------------------------------------------------
module scle_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  scle_pkg::cmd_t cmd,
  output scle_pkg::stat_t stat,
  input  logic           out_free,
  input  logic [7:0]     in_byte,
  output scle_pkg::res_t result
);
  import scle_pkg::*;

  logic [7:0]        byte_r;
  logic [1:0]        skip_r, skip_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  drop_r, drop_nxt;
  logic              fault_r, fault_nxt;
  logic [FILL_W-1:0] emit_n_r;
  logic [FILL_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]        rd_data_r;
  logic [7:0]        line_mem [LINE_DEPTH];

  logic [6:0] code;
  logic       press;
  logic       in_range;
  logic [7:0] ch;
  act_t       act;

  assign code     = byte_r[6:0];
  assign press    = (byte_r & RELEASE_BIT) == 8'h00;
  assign in_range = (code >= CODE_FIRST) && (code <= CODE_LAST);
  assign ch       = in_range ? CHAR_ROM[code - 7'd1] : NONE_CH;

  always_comb begin
    if (fault_r) begin
      act = ACT_HELD;
    end else if (skip_r != 2'd0) begin
      act = ACT_SKIP;
    end else if (code == CODE_PREFIX1) begin
      act = ACT_PFX1;
    end else if (code == CODE_PREFIX2) begin
      act = ACT_PFX2;
    end else if (!in_range) begin
      act = ACT_FAULT;
    end else if (!press) begin
      act = ACT_NONE;
    end else if (code == CODE_BACKSPACE && fill_r != '0) begin
      act = ACT_BKSP;
    end else if (ch == NEWLINE_CH) begin
      act = (fill_r != '0) ? ACT_EMIT : ACT_NONE;
    end else if (fill_r >= FILL_MAX) begin
      act = ACT_DROP;
    end else if (ch != NONE_CH) begin
      act = ACT_APPEND;
    end else begin
      act = ACT_NONE;
    end
  end

  always_comb begin
    skip_nxt  = skip_r;
    fill_nxt  = fill_r;
    drop_nxt  = drop_r;
    fault_nxt = fault_r;
    if (cmd.exec) begin
      case (act)
        ACT_SKIP:   skip_nxt  = skip_r - 2'd1;
        ACT_PFX1:   skip_nxt  = 2'd1;
        ACT_PFX2:   skip_nxt  = 2'd2;
        ACT_FAULT:  fault_nxt = 1'b1;
        ACT_BKSP:   fill_nxt  = fill_r - 1'b1;
        ACT_EMIT:   fill_nxt  = '0;
        ACT_DROP: begin
          if (drop_r != CNT_SAT) begin
            drop_nxt = drop_r + 1'b1;
          end
        end
        ACT_APPEND: fill_nxt  = fill_r + 1'b1;
        default: ;
      endcase
    end
  end

  // read address runs one step ahead so each emit cycle finds its char ready
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.exec) begin
      rd_idx_nxt = '0;
    end else if (cmd.emit_load) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r  <= 2'd0;
      fill_r  <= '0;
      drop_r  <= '0;
      fault_r <= 1'b0;
    end else begin
      skip_r  <= skip_nxt;
      fill_r  <= fill_nxt;
      drop_r  <= drop_nxt;
      fault_r <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_r <= in_byte;
    end
    if (cmd.exec && act == ACT_EMIT) begin
      emit_n_r <= fill_r;
    end
    rd_idx_r <= rd_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && act == ACT_APPEND) begin
      line_mem[fill_r] <= ch;
    end
    rd_data_r <= line_mem[rd_idx_nxt];
  end

  assign stat.is_emit   = (act == ACT_EMIT);
  assign stat.emit_last = ({1'b0, rd_idx_r} + 1'b1) == {1'b0, emit_n_r};
  assign stat.out_free  = out_free;

  always_comb begin
    result.overflow_count = drop_r;
    result.line_length    = LEN_W'(fill_r);
    if (cmd.emit_load) begin
      result.kind      = KIND_LINE;
      result.character = rd_data_r;
      result.last      = stat.emit_last;
    end else begin
      result.kind      = fault_r ? KIND_FAULT : KIND_STATUS;
      result.character = 8'h00;
      result.last      = 1'b1;
    end
  end

endmodule

// ===== rtl/scle_ctrl.sv =====
// ----------------------------------------------------------------------------
// scle_ctrl: sequencing state machine
// Takes one byte, runs its update, then sends a status item or walks the
// line out one character per cycle while the output register is free.
// ----------------------------------------------------------------------------
module scle_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  scle_pkg::stat_t stat,
  output scle_pkg::cmd_t  cmd
);
  import scle_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = stat.is_emit ? S_EMIT : S_STAT;
      end
      S_STAT: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free && stat.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_EXEC: cmd.exec      = 1'b1;
      S_STAT: cmd.stat_load = stat.out_free;
      S_EMIT: cmd.emit_load = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.stat_load || cmd.emit_load) |-> stat.out_free)
    else $error("result loaded while output register is busy");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EXEC))
    else $error("accepted item not executed next cycle");

  a_stat_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stat_load |=> (state_r == S_IDLE) && in_tready)
    else $error("status item did not return to idle");

  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && stat.emit_last) |=> (state_r == S_IDLE))
    else $error("line emit ran past its last character");

endmodule

// ===== rtl/scancode_line_editor_core.sv =====
// ----------------------------------------------------------------------------
// scancode_line_editor_core: set 1 scancode line editor
// Turns keyboard bytes into an edited line and emits it on Enter.
// ----------------------------------------------------------------------------
// An accepted byte is captured in S_IDLE and applied in S_EXEC; its first
//   result item is loaded from S_STAT or S_EMIT. No new byte before S_IDLE.
// Enter sends the held line one character per cycle while the output
//   register is free, set by the single line store read port.
// Output stalls hold the sequencer; the next byte is taken while a status
//   item still waits in the output register.
// Reset (rst_n low, synchronous) clears skip, fill, overflow count, fault and
//   handshake state; the line store is not cleared.
module scancode_line_editor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scancode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] character, [12:8] line_length,
                                  // [28:13] overflow_count, [31:29] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);
  import scle_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  res_t  result;
  res_t  out_res;
  logic  out_free;

  scle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  scle_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .out_free (out_free),
    .in_byte  (in_tdata),
    .result   (result)
  );

  scle_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (cmd.stat_load || cmd.emit_load),
    .load_data  (result),
    .free       (out_free),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_data   (out_res)
  );

  assign out_tdata = {3'b000, out_res.overflow_count, out_res.line_length,
                      out_res.character};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule
